[sv/ffba_pkg.sv]
// ffba_pkg: shared types and constants of the first-fit block allocator
// payload structs, controller state type and status struct; no dependencies
`timescale 1ns / 1ps

package ffba_pkg;

   // fixed field widths of the request and response transactions
   localparam int IDX_FIELD_W = 4;
   localparam int AMT_W       = 16;
   localparam int CFG_CNT_W   = 5;

   // csr port geometry and register map
   localparam int PADDR_W           = 3;
   localparam int PDATA_W           = 32;
   localparam bit REG_BLOCKS_IN_USE = 1'b0;

   // request kinds
   localparam bit KIND_LOAD  = 1'b0;
   localparam bit KIND_ALLOC = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [IDX_FIELD_W-1:0] load_index;
      logic [AMT_W-1:0]       amount;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [IDX_FIELD_W-1:0] block_number;
      logic [AMT_W-1:0]       block_size;
      logic [AMT_W-1:0]       unused_after;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELIVER
   } state_type;

   // controller status seen by the top level
   typedef struct packed {
      logic idle;
      logic deliver;
      logic ram_rd;
      logic ram_wr;
   } status_type;

endpackage

[sv/ffba_ram.sv]
// ffba_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ffba_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ffba_ctrl.sv]
// ffba_ctrl: block table sequencer, load writes and the first-fit scan with write-back
// depends on ffba_pkg and ffba_ram
`timescale 1ns / 1ps

module ffba_ctrl #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ffba_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ffba_pkg::rsp_type                rsp_data,
   input  logic [ffba_pkg::CFG_CNT_W-1:0]   blocks_in_use,
   output ffba_pkg::status_type             status
);

   import ffba_pkg::*;

   localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int LIM_W  = ((CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W) + 1;
   localparam int WORD_W = 2 * SIZE_BITS;
   localparam logic [LIM_W-1:0] NB_LIM = LIM_W'(NUM_BLOCKS);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SIZE_BITS-1:0] amount_ff, amount_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_load;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;

   logic                 accept;
   logic [LIM_W-1:0]     lim_ext, limit, next_idx, load_ext;
   logic [SIZE_BITS+AMT_W-1:0] req_amt_ext;
   logic [SIZE_BITS-1:0] req_amt, rd_rem, rd_orig, new_rem;
   logic [IDX_W+IDX_FIELD_W-1:0] load_addr_ext, bn_ext;
   logic [SIZE_BITS+AMT_W-1:0]   bs_ext, ua_ext;
   logic                 hit;

   // block table: original size in the upper half, remaining size in the lower half
   ffba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // search limit, request fields and compare of the entry just read
   always_comb begin
      lim_ext       = {{(LIM_W - CFG_CNT_W){1'b0}}, blocks_in_use};
      limit         = (lim_ext > NB_LIM) ? NB_LIM : lim_ext;
      next_idx      = {{(LIM_W - IDX_W){1'b0}}, idx_ff} + LIM_W'(1);
      load_ext      = {{(LIM_W - IDX_FIELD_W){1'b0}}, req_data.load_index};
      load_addr_ext = {{IDX_W{1'b0}}, req_data.load_index};
      req_amt_ext   = {{SIZE_BITS{1'b0}}, req_data.amount};
      req_amt       = req_amt_ext[SIZE_BITS-1:0];
      rd_rem        = rd_data[SIZE_BITS-1:0];
      rd_orig       = rd_data[WORD_W-1:SIZE_BITS];
      hit           = (rd_rem >= amount_ff);
      new_rem       = rd_rem - amount_ff;
      bn_ext        = {{IDX_FIELD_W{1'b0}}, idx_ff};
      bs_ext        = {{AMT_W{1'b0}}, rd_orig};
      ua_ext        = {{AMT_W{1'b0}}, new_rem};
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state, ram control and result capture
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      amount_in = amount_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = {rd_orig, new_rem};
      rd_en     = 1'b0;
      rd_addr   = '0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.kind == KIND_LOAD) begin
                  // loads beyond the table are dropped
                  wr_en   = (load_ext < NB_LIM);
                  wr_addr = load_addr_ext[IDX_W-1:0];
                  wr_data = {req_amt, req_amt};
               end else begin
                  amount_in = req_amt;
                  idx_in    = '0;
                  if (limit == '0) begin
                     res_in   = '0;
                     state_in = ST_DELIVER;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               // write back the reduced remaining size
               wr_en               = 1'b1;
               res_in.found        = 1'b1;
               res_in.block_number = bn_ext[IDX_FIELD_W-1:0];
               res_in.block_size   = bs_ext[AMT_W-1:0];
               res_in.unused_after = ua_ext[AMT_W-1:0];
               state_in            = ST_DELIVER;
            end else if (next_idx >= limit) begin
               res_in   = '0;
               state_in = ST_DELIVER;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = next_idx[IDX_W-1:0];
               idx_in   = next_idx[IDX_W-1:0];
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_data_in  = rsp_load ? res_ff : rsp_data_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      amount_ff   <= amount_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.idle    = (state_ff == ST_IDLE);
   assign status.deliver = (state_ff == ST_DELIVER);
   assign status.ram_rd  = rd_en;
   assign status.ram_wr  = wr_en;

endmodule

[sv/first_fit_block_allocator.sv]
// first_fit_block_allocator: top level, csr register and the table sequencer
// depends on ffba_pkg and ffba_ctrl
`timescale 1ns / 1ps
//
// Usage
//   req channel (valid/ready) carries load and allocate transactions. A load
//   writes one block's size as both its original and remaining size and
//   returns nothing. An allocate searches blocks 0 .. limit-1 for the first
//   one whose remaining size covers the request, subtracts the request and
//   returns one rsp transaction (found, block number, original size, rest).
//   limit is blocks_in_use (csr register at byte address 0), capped at
//   NUM_BLOCKS; write it only while the block is idle.
// Timing
//   A load is written in the cycle of acceptance. An allocate goes from idle to
//   scan, which tests positions 0 .. limit-1 up to the first fit or the end of
//   the range, then to deliver and back to idle; limit 0 skips the scan.
//   The scan reads one table entry per cycle through the single read port of
//   the table ram. The result sits in an output register, so a stalled rsp side
//   does not stop new loads; a second result waits until the first is taken.
// Reset
//   Reset clears the sequencer state, the output valid flag and blocks_in_use. The
//   table contents are undefined until loaded; there is no clearing pass.

module first_fit_block_allocator #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ffba_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ffba_pkg::rsp_type              rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ffba_pkg::PADDR_W-1:0]   csr_paddr,
   input  logic [ffba_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic [ffba_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                           csr_pready
);

   import ffba_pkg::*;

   logic [CFG_CNT_W-1:0] blocks_in_use_ff, blocks_in_use_in;
   logic                 csr_wr;
   status_type           status;

   // csr write transaction
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      blocks_in_use_in = blocks_in_use_ff;
      if (csr_wr && (csr_paddr[2] == REG_BLOCKS_IN_USE)) begin
         blocks_in_use_in = csr_pwdata[CFG_CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_in_use_ff <= '0;
      end else begin
         blocks_in_use_ff <= blocks_in_use_in;
      end
   end

   // csr read data
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_BLOCKS_IN_USE) begin
         csr_prdata = {{(PDATA_W - CFG_CNT_W){1'b0}}, blocks_in_use_ff};
      end
   end

   // table sequencer
   ffba_ctrl #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .blocks_in_use (blocks_in_use_ff),
      .status        (status)
   );

   // table reads and writes never share a cycle
   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(status.ram_rd && status.ram_wr))
      else $error("table read and write in the same cycle");

   // an accepted allocate keeps the sequencer busy the next cycle
   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.kind == KIND_ALLOC)) |=> !status.idle)
      else $error("allocate transaction did not start a search");

   // a new result only comes out of the deliver state
   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(status.deliver))
      else $error("response raised outside the deliver state");

endmodule
